[hw/rtl/ile_pkg.sv]
// shared types and constants for the indexed list engine
`default_nettype none

package ile_pkg;

    // list storage geometry
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed field widths of the request and result transfers
    localparam int OP_W     = 4;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CNTO_W   = 5;

    // common width for comparing a position against the length
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // packed widths on the stream buses
    localparam int S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + CNTO_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 4'd0,
        OP_PREPEND   = 4'd1,
        OP_DEL_FIRST = 4'd2,
        OP_DEL_LAST  = 4'd3,
        OP_GET       = 4'd4,
        OP_SET       = 4'd5,
        OP_INSERT    = 4'd6,
        OP_DEL_AT    = 4'd7,
        OP_REVERSE   = 4'd8
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_GET,
        S_REV_WLO,
        S_REV_WHI,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/indexed_list_engine.sv]
// indexed list engine: ordered list of signed values kept in a two-read-port memory
//
// Each request transfer carries an operation in tuser and a position and value in
// tdata; each one yields exactly one result transfer with status, the value read by
// get and the length afterwards. Append, set, delete last and failed requests go
// straight to the result stage; get first reads the element. Prepend, insert and the
// deletes that close a gap move one element per cycle through the element memory;
// the number moved is the number of elements behind the position, up to CAPACITY-1.
// Reverse swaps one pair at a time, writing the low and then the high entry on the
// memory's single write port. A new request is taken once the previous one has
// finished its memory work and its result has entered the output register, even
// while that result still waits there. Reset gives an empty list; no clearing pass
// runs, since no entry is read before it is written.
`default_nettype none

module indexed_list_engine
    import ile_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // position[7:0], data_in[39:8]
    input  wire logic [OP_W-1:0]      s_axis_tuser,   // op[3:0]
    // result channel
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,   // data_out[31:0], count_out[36:32]
    output logic [STATUS_W-1:0]       m_axis_tuser    // status[1:0]
);

    // element memory
    logic [DATA_W-1:0] mem [CAPACITY];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;

    // sequencer registers
    t_state            r_state,      n_state;
    logic [CNT_W-1:0]  r_count,      n_count;
    logic [ADDR_W-1:0] r_pos,        n_pos;
    logic [DATA_W-1:0] r_val,        n_val;
    logic              r_up,         n_up;
    logic [CNT_W-1:0]  r_left,       n_left;
    logic [CNT_W-1:0]  r_src,        n_src;
    logic [ADDR_W-1:0] r_dst,        n_dst;
    logic              r_wpend,      n_wpend;
    logic [ADDR_W-1:0] r_lo,         n_lo;
    logic [ADDR_W-1:0] r_hi,         n_hi;
    logic [DATA_W-1:0] r_tmp,        n_tmp;
    t_status           r_res_status, n_res_status;
    logic [DATA_W-1:0] r_res_data,   n_res_data;

    // output register
    logic              r_out_valid,  n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [DATA_W-1:0] r_out_data,   n_out_data;
    logic [CNTO_W-1:0] r_out_count,  n_out_count;

    // request fields
    t_op               in_op;
    logic [POS_W-1:0]  in_pos;
    logic [DATA_W-1:0] in_val;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  cnt_c;
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] lo_inc;
    logic [ADDR_W-1:0] hi_dec;

    assign in_op  = t_op'(s_axis_tuser);
    assign in_pos = s_axis_tdata[POS_W-1:0];
    assign in_val = s_axis_tdata[POS_W+DATA_W-1:POS_W];
    assign pos_c  = CMP_W'(in_pos);
    assign cnt_c  = CMP_W'(r_count);
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign empty  = (r_count == '0);
    assign lo_inc = r_lo + ADDR_W'(1);
    assign hi_dec = r_hi - ADDR_W'(1);

    // memory with one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a <= mem[raddr_a];
        rd_b <= mem[raddr_b];
    end

    // state register and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wpend     <= n_wpend;
            r_out_valid <= n_out_valid;
        end
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_up         <= n_up;
        r_left       <= n_left;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_tmp        <= n_tmp;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_count  <= n_out_count;
    end

    // next state, memory control and result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_val        = r_val;
        n_up         = r_up;
        n_left       = r_left;
        n_src        = r_src;
        n_dst        = r_dst;
        n_wpend      = r_wpend;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_tmp        = r_tmp;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_count  = r_out_count;
        n_out_valid  = r_out_valid & ~m_axis_tready;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        raddr_a      = '0;
        raddr_b      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res_status = ST_OK;
                    n_res_data   = '0;
                    n_state      = S_DONE;
                    n_val        = in_val;
                    n_wpend      = 1'b0;
                    case (in_op) inside
                        OP_APPEND: begin
                            if (full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[ADDR_W-1:0];
                                mem_wdata = in_val;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        OP_PREPEND, OP_INSERT: begin
                            if (full) begin
                                n_res_status = ST_FULL;
                            end else if (in_op == OP_INSERT && pos_c > cnt_c) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                // open a gap, walking down from the tail
                                n_pos   = (in_op == OP_INSERT) ? in_pos[ADDR_W-1:0] : '0;
                                n_up    = 1'b1;
                                n_left  = (in_op == OP_INSERT) ?
                                          CNT_W'(cnt_c - pos_c) : r_count;
                                n_src   = r_count - CNT_W'(1);
                                n_state = S_SHIFT;
                            end
                        end
                        OP_DEL_FIRST, OP_DEL_AT: begin
                            if (empty) begin
                                n_res_status = ST_EMPTY;
                            end else if (in_op == OP_DEL_AT && pos_c >= cnt_c) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                // close the gap, walking up toward the tail
                                n_pos   = (in_op == OP_DEL_AT) ? in_pos[ADDR_W-1:0] : '0;
                                n_up    = 1'b0;
                                n_left  = (in_op == OP_DEL_AT) ?
                                          CNT_W'(cnt_c - pos_c - CMP_W'(1)) :
                                          r_count - CNT_W'(1);
                                n_src   = (in_op == OP_DEL_AT) ?
                                          CNT_W'(pos_c + CMP_W'(1)) : CNT_W'(1);
                                n_state = S_SHIFT;
                            end
                        end
                        OP_DEL_LAST: begin
                            if (empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_GET, OP_SET: begin
                            if (empty) begin
                                n_res_status = ST_EMPTY;
                            end else if (pos_c >= cnt_c) begin
                                n_res_status = ST_RANGE;
                            end else if (in_op == OP_GET) begin
                                raddr_a = in_pos[ADDR_W-1:0];
                                n_state = S_GET;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = in_pos[ADDR_W-1:0];
                                mem_wdata = in_val;
                            end
                        end
                        OP_REVERSE: begin
                            if (empty) begin
                                n_res_status = ST_EMPTY;
                            end else if (r_count > CNT_W'(1)) begin
                                // fetch the outermost pair
                                n_lo    = '0;
                                n_hi    = ADDR_W'(r_count - CNT_W'(1));
                                raddr_a = '0;
                                raddr_b = ADDR_W'(r_count - CNT_W'(1));
                                n_state = S_REV_WLO;
                            end
                        end
                        default: begin
                            n_res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // write back the element read in the previous cycle
                if (r_wpend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_dst;
                    mem_wdata = rd_a;
                end
                if (r_left != '0) begin
                    raddr_a = r_src[ADDR_W-1:0];
                    n_dst   = r_up ? r_src[ADDR_W-1:0] + ADDR_W'(1) :
                                     r_src[ADDR_W-1:0] - ADDR_W'(1);
                    n_src   = r_up ? r_src - CNT_W'(1) : r_src + CNT_W'(1);
                    n_left  = r_left - CNT_W'(1);
                    n_wpend = 1'b1;
                end else begin
                    n_wpend = 1'b0;
                    if (!r_wpend) begin
                        if (r_up) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_pos;
                            mem_wdata = r_val;
                            n_count   = r_count + CNT_W'(1);
                        end else begin
                            n_count = r_count - CNT_W'(1);
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_GET: begin
                n_res_data = rd_a;
                n_state    = S_DONE;
            end
            S_REV_WLO: begin
                mem_we    = 1'b1;
                mem_waddr = r_lo;
                mem_wdata = rd_b;
                n_tmp     = rd_a;
                n_state   = S_REV_WHI;
            end
            S_REV_WHI: begin
                mem_we    = 1'b1;
                mem_waddr = r_hi;
                mem_wdata = r_tmp;
                // fetch the next pair inward while finishing this one
                if (lo_inc < hi_dec) begin
                    raddr_a = lo_inc;
                    raddr_b = hi_dec;
                    n_lo    = lo_inc;
                    n_hi    = hi_dec;
                    n_state = S_REV_WLO;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = r_res_data;
                    n_out_count  = CNTO_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // stream outputs
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_count, r_out_data});
    assign m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

[tb/sv/ile_list_checker.sv]
// list predictor and result checker for the indexed list engine
`timescale 1ns / 1ps

module ile_list_checker
    import ile_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel, observed
    input  logic                 i_req_tvalid,
    input  logic                 i_req_tready,
    input  logic [S_TDATA_W-1:0] i_req_tdata,   // position[7:0], data_in[39:8]
    input  logic [OP_W-1:0]      i_req_tuser,   // op[3:0]
    // result channel, observed
    input  logic                 i_rsp_tvalid,
    input  logic                 i_rsp_tready,
    input  logic [M_TDATA_W-1:0] i_rsp_tdata,   // data_out[31:0], count_out[36:32]
    input  logic [STATUS_W-1:0]  i_rsp_tuser,   // status[1:0]
    // to the testbench top
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_list_len
);

    typedef struct packed {
        t_status              status;
        logic [DATA_W-1:0]    value;
        logic [CNTO_W-1:0]    length;
    } t_list_result;

    // shadow copy of the list held by the block
    logic [DATA_W-1:0] shadow_elems [CAPACITY];
    int                shadow_len = 0;
    int                mismatches = 0;
    t_list_result      awaited_results [$];

    // apply one request to the shadow list and return the result it must give
    function automatic t_list_result apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                   logic [DATA_W-1:0] val);
        t_list_result      res;
        logic [DATA_W-1:0] swap;
        int                at;
        int                lo;
        int                hi;
        int                i;
        bit                full;
        bit                empty;
        res.status = ST_OK;
        res.value  = '0;
        at    = int'(pos);
        full  = (shadow_len >= CAPACITY);
        empty = (shadow_len == 0);
        case (op)
            OP_APPEND: begin
                if (full) res.status = ST_FULL;
                else begin
                    shadow_elems[shadow_len] = val;
                    shadow_len++;
                end
            end
            OP_PREPEND: begin
                if (full) res.status = ST_FULL;
                else begin
                    for (i = shadow_len; i > 0; i--) shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[0] = val;
                    shadow_len++;
                end
            end
            OP_DEL_FIRST: begin
                if (empty) res.status = ST_EMPTY;
                else begin
                    for (i = 0; i + 1 < shadow_len; i++) shadow_elems[i] = shadow_elems[i+1];
                    shadow_len--;
                end
            end
            OP_DEL_LAST: begin
                if (empty) res.status = ST_EMPTY;
                else shadow_len--;
            end
            OP_GET: begin
                if (empty) res.status = ST_EMPTY;
                else if (at >= shadow_len) res.status = ST_RANGE;
                else res.value = shadow_elems[at];
            end
            OP_SET: begin
                if (empty) res.status = ST_EMPTY;
                else if (at >= shadow_len) res.status = ST_RANGE;
                else shadow_elems[at] = val;
            end
            OP_INSERT: begin
                if (full) res.status = ST_FULL;
                else if (at > shadow_len) res.status = ST_RANGE;
                else begin
                    for (i = shadow_len; i > at; i--) shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[at] = val;
                    shadow_len++;
                end
            end
            OP_DEL_AT: begin
                if (empty) res.status = ST_EMPTY;
                else if (at >= shadow_len) res.status = ST_RANGE;
                else begin
                    for (i = at; i + 1 < shadow_len; i++) shadow_elems[i] = shadow_elems[i+1];
                    shadow_len--;
                end
            end
            OP_REVERSE: begin
                if (empty) res.status = ST_EMPTY;
                else begin
                    lo = 0;
                    hi = shadow_len - 1;
                    while (lo < hi) begin
                        swap             = shadow_elems[lo];
                        shadow_elems[lo] = shadow_elems[hi];
                        shadow_elems[hi] = swap;
                        lo++;
                        hi--;
                    end
                end
            end
            // unused codes leave the list alone
            default: ;
        endcase
        res.length = CNTO_W'(shadow_len);
        return res;
    endfunction

    // watch both channels on every rising edge
    always @(posedge i_clk) begin : watch_channels
        t_list_result want;
        if (!i_rst_n) begin
            shadow_len = 0;
            awaited_results.delete();
        end else begin
            // result transfer against the oldest prediction
            if (i_rsp_tvalid && i_rsp_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_rsp_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_rsp_tuser);
                        mismatches++;
                    end
                    if (i_rsp_tdata[31:0] !== want.value) begin
                        $error("data_out mismatch: expected %h, actual %h",
                               want.value, i_rsp_tdata[31:0]);
                        mismatches++;
                    end
                    if (i_rsp_tdata[36:32] !== want.length) begin
                        $error("count_out mismatch: expected %0d, actual %0d",
                               want.length, i_rsp_tdata[36:32]);
                        mismatches++;
                    end
                end
            end
            // request transfer updates the shadow list
            if (i_req_tvalid && i_req_tready)
                awaited_results.push_back(apply_list_op(i_req_tuser, i_req_tdata[7:0],
                                                        i_req_tdata[39:8]));
        end
        o_fail_count = mismatches;
        o_pending    = awaited_results.size();
        o_list_len   = shadow_len;
    end

endmodule

[tb/sv/tb_indexed_list_engine.sv]
// testbench top for the indexed list engine: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_indexed_list_engine;
    import ile_pkg::*;

    localparam int RANDOM_ITEMS = 1125;
    localparam int PHASE_ITEMS  = 40;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 50;

    localparam logic [OP_W-1:0]   OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0]   OP_UNUSED_HI = 4'd15;
    localparam logic [DATA_W-1:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX      = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_ONES     = 32'hFFFF_FFFF;
    localparam logic [POS_W-1:0]  POS_TOP      = 8'hFF;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} t_phase;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // position[7:0], data_in[39:8]
    logic [OP_W-1:0]      s_axis_tuser;   // op[3:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // data_out[31:0], count_out[36:32]
    logic [STATUS_W-1:0]  m_axis_tuser;   // status[1:0]

    int chk_fails;
    int chk_pending;
    int chk_len;
    int reqs_sent = 0;
    bit sender_quiet = 0;

    indexed_list_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ile_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_tvalid (s_axis_tvalid),
        .i_req_tready (s_axis_tready),
        .i_req_tdata  (s_axis_tdata),
        .i_req_tuser  (s_axis_tuser),
        .i_rsp_tvalid (m_axis_tvalid),
        .i_rsp_tready (m_axis_tready),
        .i_rsp_tdata  (m_axis_tdata),
        .i_rsp_tuser  (m_axis_tuser),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_list_len   (chk_len)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // element index: mostly inside the list, some at the edge, a few anywhere
    function automatic logic [POS_W-1:0] pick_position(t_op op, int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return POS_W'($urandom_range(0, 255));
        if (r < 15) return POS_W'(len + $urandom_range(0, 1));
        if (op == OP_INSERT) return POS_W'($urandom_range(0, len));
        return (len > 0) ? POS_W'($urandom_range(0, len - 1)) : '0;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return VAL_MIN;
        if (r < 8) return VAL_MAX;
        if (r < 11) return '0;
        if (r < 14) return VAL_ONES;
        if (r < 25) return DATA_W'($urandom_range(0, 31));
        return $urandom;
    endfunction

    // offer one request and wait for its transfer; entered and left at a falling edge
    task automatic send_req(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
        int gap;
        gap = sender_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {val, pos};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        reqs_sent++;
        @(negedge i_clk);
    endtask

    // request stimulus, end of run and verdict
    initial begin : stimulus
        t_op    grow_ops [3];
        t_op    shrink_ops [3];
        t_op    op;
        t_phase phase;
        int     done;
        int     r;
        grow_ops   = '{OP_APPEND, OP_PREPEND, OP_INSERT};
        shrink_ops = '{OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // every failing case on an empty list
        send_req(OP_DEL_FIRST, '0, '0);
        send_req(OP_DEL_LAST, '0, '0);
        send_req(OP_REVERSE, '0, '0);
        send_req(OP_GET, '0, '0);
        send_req(OP_SET, '0, VAL_MAX);
        send_req(OP_DEL_AT, '0, '0);
        send_req(OP_INSERT, 8'd1, VAL_MAX);
        // build a short list with extreme values
        send_req(OP_INSERT, '0, VAL_MIN);
        send_req(OP_APPEND, '0, VAL_MAX);
        send_req(OP_PREPEND, '0, VAL_ONES);
        send_req(OP_INSERT, 8'd3, '0);               // position equal to length appends
        send_req(OP_INSERT, 8'd5, '0);               // past the end
        send_req(OP_GET, POS_TOP, '0);
        send_req(OP_GET, 8'd3, '0);
        send_req(OP_SET, 8'd1, 32'h1234_5678);
        send_req(OP_SET, 8'd4, 32'h1234_5678);
        send_req(OP_GET, 8'd1, '0);
        send_req(OP_REVERSE, '0, '0);
        send_req(OP_GET, '0, '0);
        send_req(OP_DEL_AT, 8'd1, '0);
        send_req(OP_DEL_AT, 8'd3, '0);
        send_req(OP_DEL_FIRST, '0, '0);
        send_req(OP_DEL_LAST, '0, '0);
        send_req(OP_UNUSED_LO, POS_TOP, VAL_ONES);
        send_req(OP_UNUSED_HI, POS_TOP, VAL_ONES);
        send_req(OP_GET, '0, '0);

        // random phases that push the list to full, to empty, or churn it
        done  = 0;
        phase = PH_MIX;
        while (done < RANDOM_ITEMS) begin
            if (done % PHASE_ITEMS == 0) begin
                phase        = t_phase'($urandom_range(PH_GROW, PH_MIX));
                sender_quiet = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 2) begin
                // occasional noise on the unused codes
                send_req(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                         POS_W'($urandom_range(0, 255)), $urandom);
            end else begin
                if (phase == PH_GROW && r < 75)
                    op = grow_ops[$urandom_range(0, 2)];
                else if (phase == PH_SHRINK && r < 70)
                    op = shrink_ops[$urandom_range(0, 2)];
                else
                    op = t_op'($urandom_range(OP_APPEND, OP_REVERSE));
                send_req(op, pick_position(op, chk_len), pick_value());
                done++;
            end
        end
        s_axis_tvalid = 1'b0;

        // let outstanding results drain, then watch for strays
        while (chk_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (chk_fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure, with one long hold-off while requests keep coming
    initial begin : result_sink
        int  stall;
        int  run;
        bit  held;
        stall = 0;
        run   = 0;
        held  = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && reqs_sent >= HOLD_START) begin
                held          = 1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else if (run > 0) begin
                m_axis_tready = 1'b1;
                run--;
            end else begin
                if ($urandom_range(0, 9) == 0) run = $urandom_range(20, 80);
                stall         = pick_gap();
                m_axis_tready = (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    // stall watchdog: too long without any transfer ends the run
    initial begin : watchdog
        int idle;
        idle = 0;
        wait (i_rst_n);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[indexed_list_engine.f]
hw/rtl/ile_pkg.sv
hw/rtl/indexed_list_engine.sv
tb/sv/ile_list_checker.sv
tb/sv/tb_indexed_list_engine.sv
